FILE: rtl/core/tff_pkg.sv
// Shared types, constants and the divider step for the trapezoid transfer function.
package tff_pkg;

  localparam int unsigned TABLE_SIZE = 256;
  localparam logic [7:0]  TblLast    = 8'(TABLE_SIZE - 1);

  localparam logic [7:0] ColourR     = 8'd255;
  localparam logic [7:0] ColourMinG  = 8'd77;
  localparam logic [7:0] ColourSpanG = 8'd178;

  localparam logic [7:0] RampUpStartRst   = 8'd0;
  localparam logic [7:0] RampUpEndRst     = 8'd64;
  localparam logic [7:0] RampDownStartRst = 8'd192;
  localparam logic [7:0] RampDownEndRst   = 8'd255;

  localparam logic [1:0] CfgRampUpStart   = 2'd0;
  localparam logic [1:0] CfgRampUpEnd     = 2'd1;
  localparam logic [1:0] CfgRampDownStart = 2'd2;
  localparam logic [1:0] CfgRampDownEnd   = 2'd3;

  localparam int unsigned DivStages = 4;

  // acc: remainder in the upper byte, remaining dividend bits then quotient bits below
  typedef struct packed {
    logic [15:0] acc_a;
    logic [15:0] acc_g;
    logic [7:0]  den;
  } div_t;

  function automatic logic [15:0] div_step(input logic [15:0] acc, input logic [7:0] den);
    logic [8:0] trial;
    logic [8:0] diff;
    logic [7:0] rem;
    logic       qbit;
    trial = {acc[15:8], acc[7]};
    diff  = trial - {1'b0, den};
    qbit  = (trial >= {1'b0, den});
    rem   = qbit ? diff[7:0] : trial[7:0];
    return {rem, acc[6:0], qbit};
  endfunction

  function automatic div_t div_step2(input div_t d);
    div_t r;
    r       = d;
    r.acc_a = div_step(div_step(d.acc_a, d.den), d.den);
    r.acc_g = div_step(div_step(d.acc_g, d.den), d.den);
    return r;
  endfunction

endpackage

FILE: rtl/core/trapezoid_transfer_function.sv
// Trapezoid transfer function: density to RGBA with four programmable breakpoints.
// Pipeline from an accepted input to out_tvalid: region select, product, four divider stages, output.
// Throughput: one transaction per cycle while out_tready accepts; a low out_tready stalls the pipeline.
// The divider pipeline (two quotient bits per stage) sets the depth.
// Reset clears all valid bits and loads the breakpoints 0, 64, 192, 255; cfg_ready is always high.
module trapezoid_transfer_function (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] density
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] alpha, [15:8] red, [23:16] green, [31:24] blue
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] ramp_up_start_r, ramp_up_end_r, ramp_down_start_r, ramp_down_end_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_up_start_r   <= tff_pkg::RampUpStartRst;
      ramp_up_end_r     <= tff_pkg::RampUpEndRst;
      ramp_down_start_r <= tff_pkg::RampDownStartRst;
      ramp_down_end_r   <= tff_pkg::RampDownEndRst;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tff_pkg::CfgRampUpStart:   ramp_up_start_r   <= cfg_data;
        tff_pkg::CfgRampUpEnd:     ramp_up_end_r     <= cfg_data;
        tff_pkg::CfgRampDownStart: ramp_down_start_r <= cfg_data;
        tff_pkg::CfgRampDownEnd:   ramp_down_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: region select, ramp position and length
  logic       v1_r;
  logic [7:0] t1_r, n1_r;
  logic [7:0] x_sat, t1_nxt, n1_nxt;
  logic       rdy1, rdy2, rdy_out;

  always_comb begin
    x_sat = in_tdata;
    if (tff_pkg::TABLE_SIZE < 256 && 32'(in_tdata) >= tff_pkg::TABLE_SIZE) begin
      x_sat = tff_pkg::TblLast;
    end
    t1_nxt = 8'd0;
    n1_nxt = 8'd1;
    priority if (x_sat > ramp_down_end_r) begin
      t1_nxt = 8'd0;
      n1_nxt = 8'd1;
    end else if (x_sat > ramp_down_start_r) begin
      t1_nxt = ramp_down_end_r - x_sat;
      n1_nxt = ramp_down_end_r - ramp_down_start_r;
    end else if (x_sat > ramp_up_end_r) begin
      t1_nxt = 8'd1;
      n1_nxt = 8'd1;
    end else if (x_sat > ramp_up_start_r) begin
      t1_nxt = x_sat - ramp_up_start_r;
      n1_nxt = ramp_up_end_r - ramp_up_start_r;
    end else begin
      t1_nxt = 8'd0;
      n1_nxt = 8'd1;
    end
  end

  // Stage 2: scaled dividends
  logic          v2_r;
  tff_pkg::div_t d2_r;
  tff_pkg::div_t d2_nxt;

  always_comb begin
    d2_nxt.acc_a = {t1_r, 8'd0} - {8'd0, t1_r};
    d2_nxt.acc_g = 16'(t1_r) * 16'(tff_pkg::ColourSpanG);
    d2_nxt.den   = n1_r;
  end

  logic          div_in_ready, div_out_valid;
  tff_pkg::div_t div_q;

  tff_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (div_in_ready),
    .in_data   (d2_r),
    .out_valid (div_out_valid),
    .out_ready (rdy_out),
    .out_data  (div_q)
  );

  // Output register
  logic       out_v_r;
  logic [7:0] alpha_r, green_r;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy2      = !v2_r || div_in_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r    <= in_tvalid;
      if (rdy2)    v2_r    <= v1_r;
      if (rdy_out) out_v_r <= div_out_valid;
    end
    if (rdy1 && in_tvalid) begin
      t1_r <= t1_nxt;
      n1_r <= n1_nxt;
    end
    if (rdy2 && v1_r) begin
      d2_r <= d2_nxt;
    end
    if (rdy_out && div_out_valid) begin
      alpha_r <= div_q.acc_a[7:0];
      green_r <= tff_pkg::ColourMinG + div_q.acc_g[7:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {green_r, green_r, tff_pkg::ColourR, alpha_r};

`ifndef NO_ASSERTIONS
  a_ramp_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (n1_r != 8'd0) && (t1_r <= n1_r))
    else $error("ramp position exceeds ramp length");

  a_red_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:8] == tff_pkg::ColourR)
    else $error("red channel not full");

  a_green_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:16] == out_tdata[31:24])
                   && (out_tdata[23:16] >= tff_pkg::ColourMinG))
    else $error("green/blue mismatch or below minimum colour");

  a_opaque_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[7:0] == 8'd255) |-> out_tdata[23:16] == 8'd255)
    else $error("full alpha without maximum colour");
`endif

endmodule

FILE: rtl/core/tff_divider.sv
// Pipelined restoring divider, two quotient bits per stage, two lanes sharing one divisor.
module tff_divider (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tff_pkg::div_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tff_pkg::div_t out_data
);

  localparam int unsigned Last = tff_pkg::DivStages - 1;

  tff_pkg::div_t st_r   [tff_pkg::DivStages];
  logic          v_r    [tff_pkg::DivStages];
  tff_pkg::div_t src    [tff_pkg::DivStages];
  logic          vsrc   [tff_pkg::DivStages];
  tff_pkg::div_t st_nxt [tff_pkg::DivStages];
  logic          rdy    [tff_pkg::DivStages + 1];

  always_comb begin
    rdy[tff_pkg::DivStages] = out_ready;
    for (int i = Last; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i + 1];
    end
    src[0]  = in_data;
    vsrc[0] = in_valid;
    for (int i = 1; i <= Last; i++) begin
      src[i]  = st_r[i - 1];
      vsrc[i] = v_r[i - 1];
    end
    for (int i = 0; i <= Last; i++) begin
      st_nxt[i] = tff_pkg::div_step2(src[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i <= Last; i++) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= vsrc[i];
      end
      if (rdy[i] && vsrc[i]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[Last];
  assign out_data  = st_r[Last];

endmodule
